### rtl/core/flpa_pkg.sv
// Shared field widths, opcodes and status codes of the slot pool allocator.
package flpa_pkg;

  localparam int OPCODE_W    = 3;
  localparam int SLOT_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_INIT    = 3'd0;
  localparam opcode_t OP_ALLOC   = 3'd1;
  localparam opcode_t OP_FREE    = 3'd2;
  localparam opcode_t OP_MARK    = 3'd3;
  localparam opcode_t OP_COLLECT = 3'd4;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_RANGE  = 2'd2;
  localparam status_t ST_NOINIT = 2'd3;

  localparam logic [CFG_W-1:0] POOL_SIZE_RST = 9'd256;

endpackage

### rtl/core/free_list_pool_allocator_with_sweep.sv
// Slot pool allocator: LIFO free list in a link memory, mark-and-sweep collector.
//
// Input channel (in_*): one transfer carries an opcode and a slot index. Result
// channel (out_*): one transfer per input item with the granted slot and a status.
// Configuration: cfg_wr_en writes pool_size, which is sampled when an init is taken.
// The result of an item is registered and shows on out_tvalid the cycle after
// the input transfer. The next item is taken once the internal work is done and
// the output register is empty or being emptied in that cycle.
// Work per item, through the link memory and mark memory ports:
//   free, mark, errors, unknown opcodes: handled at the input transfer
//   alloc: one link read to advance the head
//   init: one mark write per slot of POOL_DEPTH, one link write per slot in the pool
//   collect: a walk of up to active_size steps along the free list (one link read per
//   step), then a sweep over the active_size slots (one mark read per slot).
// Reset empties the free list, clears the ready flag and sets pool_size to 256;
// memories are not cleared, init writes every entry that is later read.
// While a result is pending and out_tready is low, the result holds and in_tready stays low.
module free_list_pool_allocator_with_sweep #(
  parameter int POOL_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] opcode, [10:3] slot_index, [15:11] zero
  input  logic [flpa_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] granted_slot, [9:8] status, [15:10] zero
  output logic [flpa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [flpa_pkg::CFG_W-1:0]         cfg_wr_data
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int CW = (LW > flpa_pkg::CFG_W) ? LW : flpa_pkg::CFG_W;

  typedef enum logic [2:0] {S_IDLE, S_ALLOC, S_INIT, S_WALK, S_SWEEP} state_t;

  state_t                         state_r, state_nxt;
  logic [flpa_pkg::CFG_W-1:0]     cfg_pool_size_r;
  logic [LW-1:0]                  head_r, head_nxt;
  logic [LW-1:0]                  active_r, active_nxt;
  logic                           ready_r, ready_nxt;
  logic [LW-1:0]                  idx_r, idx_nxt;
  logic [LW-1:0]                  steps_r, steps_nxt;
  logic                           pend_r, pend_nxt;
  logic [LW-1:0]                  pend_idx_r, pend_idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [flpa_pkg::SLOT_W-1:0]    granted_r, granted_nxt;
  flpa_pkg::status_t              status_r, status_nxt;

  logic [LW-1:0] link_mem [POOL_DEPTH];
  logic          mark_mem [POOL_DEPTH];
  logic [LW-1:0] link_rd_r;
  logic          mark_rd_r;

  logic          link_we, mark_we, mark_wdata;
  logic [AW-1:0] link_waddr, link_raddr, mark_waddr, mark_raddr;
  logic [LW-1:0] link_wdata;

  flpa_pkg::opcode_t           in_op;
  logic [flpa_pkg::SLOT_W-1:0] in_idx;
  logic                        in_accept, idx_ok;
  logic [CW-1:0]               pool_ext;
  logic [LW-1:0]               init_n, idx_inc;
  logic [AW-1:0]               in_addr;

  assign in_op     = in_tdata[2:0];
  assign in_idx    = in_tdata[10:3];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;
  assign idx_ok    = CW'(in_idx) < CW'(active_r);
  assign in_addr   = AW'(CW'(in_idx));
  assign idx_inc   = idx_r + LW'(1);
  assign pool_ext  = CW'(cfg_pool_size_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, status_r, granted_r};

  always_comb begin
    if (pool_ext == '0) begin
      init_n = LW'(1);
    end else if (pool_ext > CW'(POOL_DEPTH)) begin
      init_n = LW'(POOL_DEPTH);
    end else begin
      init_n = LW'(pool_ext);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    active_nxt    = active_r;
    ready_nxt     = ready_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    link_we       = 1'b0;
    link_waddr    = '0;
    link_wdata    = '0;
    link_raddr    = AW'(head_r);
    mark_we       = 1'b0;
    mark_waddr    = '0;
    mark_wdata    = 1'b0;
    mark_raddr    = AW'(idx_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt = 1'b1;
          granted_nxt   = '0;
          status_nxt    = flpa_pkg::ST_OK;
          if (in_op == flpa_pkg::OP_INIT) begin
            active_nxt = init_n;
            head_nxt   = '0;
            ready_nxt  = 1'b1;
            idx_nxt    = '0;
            state_nxt  = S_INIT;
          end else if (in_op <= flpa_pkg::OP_COLLECT && !ready_r) begin
            status_nxt = flpa_pkg::ST_NOINIT;
          end else begin
            priority case (in_op)
              flpa_pkg::OP_ALLOC: begin
                if (head_r < active_r) begin
                  granted_nxt = flpa_pkg::SLOT_W'(CW'(head_r));
                  state_nxt   = S_ALLOC;
                end else begin
                  status_nxt = flpa_pkg::ST_EMPTY;
                end
              end
              flpa_pkg::OP_FREE: begin
                if (idx_ok) begin
                  link_we    = 1'b1;
                  link_waddr = in_addr;
                  link_wdata = head_r;
                  head_nxt   = LW'(CW'(in_idx));
                end else begin
                  status_nxt = flpa_pkg::ST_RANGE;
                end
              end
              flpa_pkg::OP_MARK: begin
                if (idx_ok) begin
                  mark_we    = 1'b1;
                  mark_waddr = in_addr;
                  mark_wdata = 1'b1;
                end else begin
                  status_nxt = flpa_pkg::ST_RANGE;
                end
              end
              flpa_pkg::OP_COLLECT: begin
                if (head_r < active_r) begin
                  mark_we    = 1'b1;
                  mark_waddr = AW'(head_r);
                  mark_wdata = 1'b1;
                  steps_nxt  = LW'(1);
                  state_nxt  = S_WALK;
                end else begin
                  idx_nxt   = '0;
                  pend_nxt  = 1'b0;
                  state_nxt = S_SWEEP;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_ALLOC: begin
        head_nxt  = link_rd_r;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        mark_we    = 1'b1;
        mark_waddr = AW'(idx_r);
        mark_wdata = 1'b0;
        if (idx_r < active_r) begin
          link_we    = 1'b1;
          link_waddr = AW'(idx_r);
          link_wdata = (idx_inc < active_r) ? idx_inc : LW'(POOL_DEPTH);
        end
        if (idx_r == LW'(POOL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_WALK: begin
        if (link_rd_r < active_r && steps_r < active_r) begin
          mark_we    = 1'b1;
          mark_waddr = AW'(link_rd_r);
          mark_wdata = 1'b1;
          link_raddr = AW'(link_rd_r);
          steps_nxt  = steps_r + LW'(1);
        end else begin
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (pend_r) begin
          mark_we    = 1'b1;
          mark_waddr = AW'(pend_idx_r);
          mark_wdata = 1'b0;
          if (!mark_rd_r) begin
            link_we    = 1'b1;
            link_waddr = AW'(pend_idx_r);
            link_wdata = head_r;
            head_nxt   = pend_idx_r;
          end
        end
        if (idx_r < active_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_inc;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cfg_pool_size_r <= flpa_pkg::POOL_SIZE_RST;
      head_r          <= LW'(POOL_DEPTH);
      active_r        <= '0;
      ready_r         <= 1'b0;
      idx_r           <= '0;
      steps_r         <= '0;
      pend_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        cfg_pool_size_r <= cfg_wr_data;
      end
      head_r      <= head_nxt;
      active_r    <= active_nxt;
      ready_r     <= ready_nxt;
      idx_r       <= idx_nxt;
      steps_r     <= steps_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    granted_r  <= granted_nxt;
    status_r   <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_r <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_r <= mark_mem[mark_raddr];
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("input transfer without a result");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("input taken while busy");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != flpa_pkg::ST_OK |-> granted_r == '0)
    else $error("slot granted with error status");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> steps_r <= active_r)
    else $error("free list walk overran the pool");

  a_collect_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK || state_r == S_SWEEP || state_r == S_ALLOC |-> ready_r)
    else $error("pool operation before init");

endmodule
